@@ rtl/pnt_pkg.sv @@
// Package for the perfect number test: widths and the divider result type.
// Used by pnt_divider and perfect_number_test_top; depends on nothing.
package pnt_pkg;

    // Examined candidate width, sign bit included
    localparam int NUM_BITS = 32;
    // Magnitude bits of a non-negative candidate
    localparam int W = NUM_BITS - 1;
    // Trial divisor width: d never exceeds floor(sqrt(n)) + 1
    localparam int DW = (W + 1) / 2 + 1;
    // Divisor sum width: the sum stays below three times the candidate
    localparam int TW = W + 2;
    // Divider step counter width
    localparam int CW = $clog2(W);

    // Divider status and result handed to the sequencer
    typedef struct packed {
        logic         busy;
        logic         done;
        logic [W-1:0] quo;
        logic [W-1:0] rem;
    } t_div_res;

endpackage

@@ rtl/pnt_divider.sv @@
// Bit-serial restoring divider: one quotient bit per cycle, W restoring steps per division.
// Depends on pnt_pkg for widths and the result struct.
module pnt_divider
    import pnt_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output t_div_res     o_res
);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_div;

    logic [W:0]    w_trial;
    logic [W:0]    w_diff;
    logic          w_fit;

    // Shift the next dividend bit into the partial remainder and try a subtract
    assign w_trial = {r_rem, r_quo[W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_fit   = (w_trial >= {1'b0, r_div});

    // Control: busy flag, step counter, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // Datapath: load operands, then one restoring step per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[W-1:0] : w_trial[W-1:0];
            r_quo <= {r_quo[W-2:0], w_fit};
        end
    end

    assign o_res.busy = r_busy;
    assign o_res.done = r_done;
    assign o_res.quo  = r_quo;
    assign o_res.rem  = r_rem;

`ifndef NO_ASSERTIONS
    // A new division never starts on top of a running one
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider restarted while busy");

    // Done pulses in the cycle after the last step
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == '0 && !i_start) |=> (r_done && !r_busy))
        else $error("divider done pulse missing");
`endif

endmodule

@@ rtl/perfect_number_test_top.sv @@
// Each trial divisor d = 2, 3, ... costs one division in the divider (W restoring steps); when d
// divides n the sequencer also passes through S_ADD_D, S_ADD_Q and S_CHK. Zero, one or a
// negative value goes straight to S_DONE. One item at a time: the next input is taken only
// after the result is registered, and S_DONE holds while the output register is full.
// Reset (synchronous, active low) returns the sequencer to idle and empties the output.
//
// Top level of the perfect number test: sequencer, divisor sum and stream ports.
// Depends on pnt_pkg and pnt_divider.
module perfect_number_test_top
    import pnt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] candidate
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // [0] is_perfect, [7:1] zero
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_ADD_D,
        S_ADD_Q,
        S_CHK,
        S_DONE
    } t_state;

    t_state        r_state, n_state;
    logic [W-1:0]  r_n, n_n;
    logic [DW-1:0] r_d, n_d;
    logic [W-1:0]  r_q, n_q;
    logic [TW-1:0] r_total, n_total;
    logic          r_res, n_res;
    logic          r_out_valid, n_out_valid;
    logic          r_out_data, n_out_data;

    logic          w_start;
    logic          w_sign;
    logic [W-1:0]  w_mag;
    logic [W-1:0]  w_d_ext;
    t_div_res      w_div;

    assign w_sign  = i_s_tdata[NUM_BITS-1];
    assign w_mag   = i_s_tdata[W-1:0];
    assign w_d_ext = {{(W-DW){1'b0}}, n_d};

    pnt_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (n_n),
        .i_divisor  (w_d_ext),
        .o_res      (w_div)
    );

    // Next-state logic of the divisor search
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_d         = r_d;
        n_q         = r_q;
        n_total     = r_total;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_start     = 1'b0;

        // Drop the result once it is transferred
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_n = w_mag;
                    if (w_sign || w_mag < W'(2)) begin
                        n_res   = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_total = TW'(1);
                        n_d     = DW'(2);
                        w_start = 1'b1;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (w_div.done) begin
                    n_q = w_div.quo;
                    // Quotient below divisor: d*d > n, search is over
                    if (w_div.quo < {{(W-DW){1'b0}}, r_d}) begin
                        n_res   = (r_total == {2'b00, r_n});
                        n_state = S_DONE;
                    end else if (w_div.rem == '0) begin
                        n_state = S_ADD_D;
                    end else begin
                        n_d     = r_d + 1'b1;
                        w_start = 1'b1;
                    end
                end
            end
            S_ADD_D: begin
                n_total = r_total + {{(TW-DW){1'b0}}, r_d};
                n_state = S_ADD_Q;
            end
            S_ADD_Q: begin
                // Add the paired divisor unless it is the same one
                if (r_q != {{(W-DW){1'b0}}, r_d}) begin
                    n_total = r_total + {2'b00, r_q};
                end
                n_state = S_CHK;
            end
            S_CHK: begin
                if (r_total > {2'b00, r_n}) begin
                    n_res   = 1'b0;
                    n_state = S_DONE;
                end else begin
                    n_d     = r_d + 1'b1;
                    w_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DONE: begin
                // Hold until the output register is free
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_n        <= n_n;
        r_d        <= n_d;
        r_q        <= n_q;
        r_total    <= n_total;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_out_data};

`ifndef NO_ASSERTIONS
    // Divider results arrive only while the sequencer waits for them
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == S_DIV))
        else $error("divider result outside the divide state");

    // A divisor is summed only while it is within the square-root bound
    a_add_in_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD_D) |-> (r_q >= {{(W-DW){1'b0}}, r_d}))
        else $error("divisor summed beyond the bound");

    // The divider runs whenever the sequencer waits in the divide state
    a_div_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (w_div.busy || w_div.done))
        else $error("sequencer waiting on an idle divider");
`endif

endmodule
